// ===== hdl/refcounted_block_slot_map_core_defines.svh =====
// assertion macros for the slot map core
// no dependencies; included by the controller and datapath
`ifndef REFCOUNTED_BLOCK_SLOT_MAP_CORE_DEFINES_SVH
`define REFCOUNTED_BLOCK_SLOT_MAP_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define SMAP_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("slot map check failed");
`define SMAP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot map check failed");
`else
`define SMAP_ASSERT(lbl, clk, rst_n, expr)
`define SMAP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/smap_pkg.sv =====
// shared types and constants for the slot map core
// no dependencies
package smap_pkg;

    localparam int SLOTS_DEF = 32;
    localparam int FUNC_W    = 3;
    localparam int DEV_W     = 8;
    localparam int BLK_W     = 32;
    localparam int SIDX_W    = 5;
    localparam int CNT_W     = 8;
    localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

    typedef enum logic [FUNC_W-1:0] {
        FN_GET       = 3'd0,
        FN_RELEASE   = 3'd1,
        FN_PIN       = 3'd2,
        FN_UNPIN     = 3'd3,
        FN_SET_VALID = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFREE = 2'd1,
        ST_UNDER  = 2'd2
    } t_status;

    typedef struct packed {
        logic capture;
        logic update;
    } t_cmd;

endpackage

// ===== hdl/smap_ctrl.sv =====
// controller state machine for the slot map core
// depends on smap_pkg and the defines header
`include "refcounted_block_slot_map_core_defines.svh"

module smap_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    output logic              o_done,
    output smap_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: n_state = i_start ? S_EXEC : S_IDLE;
            S_EXEC: n_state = S_RESP;
            S_RESP: n_state = i_start ? S_EXEC : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy        = (r_state == S_EXEC);
    assign o_done        = (r_state == S_RESP);
    assign o_cmd.capture = i_start && !o_busy;
    assign o_cmd.update  = (r_state == S_EXEC);

    `SMAP_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `SMAP_ASSERT_NEXT(a_exec_done, i_clk, i_rst_n, o_busy, o_done && !o_busy)

endmodule

// ===== hdl/smap_dp.sv =====
// datapath of the slot map core: tags, counts, flags, free stack, result
// depends on smap_pkg and the defines header
`include "refcounted_block_slot_map_core_defines.svh"

module smap_dp #(
    parameter int SLOTS = smap_pkg::SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  smap_pkg::t_cmd               i_cmd,
    input  logic [smap_pkg::FUNC_W-1:0]  i_func,
    input  logic [smap_pkg::DEV_W-1:0]   i_device,
    input  logic [smap_pkg::BLK_W-1:0]   i_block_number,
    input  logic [smap_pkg::SIDX_W-1:0]  i_slot_index,
    output logic [smap_pkg::SIDX_W-1:0]  o_slot,
    output logic                         o_needs_read,
    output logic                         o_hit,
    output logic [1:0]                   o_status
);

    localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FCW = $clog2(SLOTS + 1);

    // stored item
    smap_pkg::t_func                r_func;
    logic [smap_pkg::DEV_W-1:0]     r_dev;
    logic [smap_pkg::BLK_W-1:0]     r_blk;
    logic [smap_pkg::SIDX_W-1:0]    r_sidx;

    // slot state
    logic [smap_pkg::DEV_W-1:0]     r_tag_dev [SLOTS];
    logic [smap_pkg::BLK_W-1:0]     r_tag_blk [SLOTS];
    logic [smap_pkg::CNT_W-1:0]     r_cnt     [SLOTS];
    logic [SLOTS-1:0]               r_mapped;
    logic [SLOTS-1:0]               r_loaded;
    logic [SW-1:0]                  r_stack   [SLOTS];
    logic [FCW-1:0]                 r_free_count;

    // result
    logic [smap_pkg::SIDX_W-1:0]    r_slot;
    logic                           r_needs_read;
    logic                           r_hit;
    smap_pkg::t_status              r_status;

    logic [SLOTS-1:0]               match;
    logic                           hit_any;
    logic [SW-1:0]                  hit_idx;
    logic [SW-1:0]                  idx;
    logic                           in_range;
    logic [SW-1:0]                  pop_slot;
    logic [SW-1:0]                  cnt_addr;
    logic [SW-1:0]                  cnt_waddr;
    logic [smap_pkg::CNT_W-1:0]     cnt_rd;
    logic [smap_pkg::CNT_W-1:0]     cnt_inc;
    logic [smap_pkg::CNT_W-1:0]     cnt_wd;
    logic                           cnt_we;
    logic                           alloc;
    logic                           unmap;
    logic                           push;
    logic                           load_set;
    logic [smap_pkg::SIDX_W-1:0]    n_slot;
    logic                           n_needs_read;
    logic                           n_hit;
    smap_pkg::t_status              n_status;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            match[i] = r_mapped[i] && (r_tag_dev[i] == r_dev) && (r_tag_blk[i] == r_blk);
        end
    end

    // lowest matching slot wins
    always_comb begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_any = 1'b1;
                hit_idx = SW'(i);
            end
        end
    end

    assign idx       = SW'(r_sidx);
    assign in_range  = (32'(r_sidx) < 32'(SLOTS));
    assign pop_slot  = r_stack[SW'(r_free_count - FCW'(1))];
    assign cnt_addr  = (r_func == smap_pkg::FN_GET) ? hit_idx : idx;
    assign cnt_rd    = r_cnt[cnt_addr];
    assign cnt_inc   = (cnt_rd == smap_pkg::COUNT_MAX) ? cnt_rd
                                                        : cnt_rd + smap_pkg::CNT_W'(1);
    assign cnt_waddr = alloc ? pop_slot : cnt_addr;

    always_comb begin
        n_slot       = r_sidx;
        n_needs_read = 1'b0;
        n_hit        = 1'b0;
        n_status     = smap_pkg::ST_OK;
        cnt_we       = 1'b0;
        cnt_wd       = cnt_rd;
        alloc        = 1'b0;
        unmap        = 1'b0;
        push         = 1'b0;
        load_set     = 1'b0;
        unique case (r_func)
            smap_pkg::FN_GET: begin
                if (hit_any) begin
                    cnt_we       = 1'b1;
                    cnt_wd       = cnt_inc;
                    n_slot       = smap_pkg::SIDX_W'(hit_idx);
                    n_needs_read = !r_loaded[hit_idx];
                    n_hit        = 1'b1;
                end else if (r_free_count == '0) begin
                    n_slot   = '0;
                    n_status = smap_pkg::ST_NOFREE;
                end else begin
                    alloc        = 1'b1;
                    cnt_we       = 1'b1;
                    cnt_wd       = smap_pkg::CNT_W'(1);
                    n_slot       = smap_pkg::SIDX_W'(pop_slot);
                    n_needs_read = 1'b1;
                end
            end
            smap_pkg::FN_RELEASE: begin
                if (in_range) begin
                    if (cnt_rd == '0) begin
                        n_status = smap_pkg::ST_UNDER;
                    end else begin
                        cnt_we = 1'b1;
                        cnt_wd = cnt_rd - smap_pkg::CNT_W'(1);
                        if ((cnt_rd == smap_pkg::CNT_W'(1)) && r_mapped[idx]) begin
                            unmap = 1'b1;
                            push  = (32'(r_free_count) < 32'(SLOTS));
                        end
                    end
                end
            end
            smap_pkg::FN_PIN: begin
                if (in_range) begin
                    cnt_we = 1'b1;
                    cnt_wd = cnt_inc;
                end
            end
            smap_pkg::FN_UNPIN: begin
                if (in_range) begin
                    if (cnt_rd == '0) begin
                        n_status = smap_pkg::ST_UNDER;
                    end else begin
                        cnt_we = 1'b1;
                        cnt_wd = cnt_rd - smap_pkg::CNT_W'(1);
                    end
                end
            end
            smap_pkg::FN_SET_VALID: begin
                load_set = in_range;
            end
            default: begin
            end
        endcase
    end

    // item capture, tags and result, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= smap_pkg::t_func'(i_func);
            r_dev  <= i_device;
            r_blk  <= i_block_number;
            r_sidx <= i_slot_index;
        end
        if (i_cmd.update && alloc) begin
            r_tag_dev[pop_slot] <= r_dev;
            r_tag_blk[pop_slot] <= r_blk;
        end
        if (i_cmd.update) begin
            r_slot       <= n_slot;
            r_needs_read <= n_needs_read;
            r_hit        <= n_hit;
            r_status     <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_cnt[i]   <= '0;
                r_stack[i] <= SW'(i);
            end
            r_mapped     <= '0;
            r_loaded     <= '0;
            r_free_count <= FCW'(SLOTS);
        end else if (i_cmd.update) begin
            if (cnt_we) begin
                r_cnt[cnt_waddr] <= cnt_wd;
            end
            if (alloc) begin
                r_mapped[pop_slot] <= 1'b1;
                r_loaded[pop_slot] <= 1'b0;
                r_free_count       <= r_free_count - FCW'(1);
            end
            if (unmap) begin
                r_mapped[idx] <= 1'b0;
            end
            if (push) begin
                r_stack[SW'(r_free_count)] <= idx;
                r_free_count               <= r_free_count + FCW'(1);
            end
            if (load_set) begin
                r_loaded[idx] <= 1'b1;
            end
        end
    end

    assign o_slot       = r_slot;
    assign o_needs_read = r_needs_read;
    assign o_hit        = r_hit;
    assign o_status     = r_status;

    `SMAP_ASSERT(a_free_bound, i_clk, i_rst_n, 32'(r_free_count) <= 32'(SLOTS))
    `SMAP_ASSERT(a_tag_unique, i_clk, i_rst_n, $onehot0(match))
    `SMAP_ASSERT_NEXT(a_alloc_pop, i_clk, i_rst_n, i_cmd.update && alloc,
        r_free_count == $past(r_free_count) - FCW'(1))

endmodule

// ===== hdl/refcounted_block_slot_map_core.sv =====
// top level of the reference-counted block slot map
// depends on smap_pkg, smap_ctrl, smap_dp
//
// channel   direction  handshake                 payload
// request   in         start high, busy low      i_func i_device i_block_number i_slot_index
// result    out        o_done strobe, one cycle  o_slot o_needs_read o_hit o_status
//
// an item goes through the parallel tag compare and state update, then has the result
// on the ports; a new item is taken during the result cycle
// the tag compare over all slots and the free stack update happen in the same cycle
// synchronous active-low reset clears counts, flags and the free stack
// the receiver cannot stall; busy is high only in the update cycle
module refcounted_block_slot_map_core #(
    parameter int SLOTS = smap_pkg::SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [smap_pkg::FUNC_W-1:0]  i_func,
    input  logic [smap_pkg::DEV_W-1:0]   i_device,
    input  logic [smap_pkg::BLK_W-1:0]   i_block_number,
    input  logic [smap_pkg::SIDX_W-1:0]  i_slot_index,
    output logic                         o_done,
    output logic [smap_pkg::SIDX_W-1:0]  o_slot,
    output logic                         o_needs_read,
    output logic                         o_hit,
    output logic [1:0]                   o_status
);

    smap_pkg::t_cmd cmd;

    smap_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    smap_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_func         (i_func),
        .i_device       (i_device),
        .i_block_number (i_block_number),
        .i_slot_index   (i_slot_index),
        .o_slot         (o_slot),
        .o_needs_read   (o_needs_read),
        .o_hit          (o_hit),
        .o_status       (o_status)
    );

endmodule
